// File: rtl/core/rtfp_pkg.sv
package rtfp_pkg;

    localparam int TARGET_SLOTS = 3;
    localparam int SLOT_BYTES   = 8;
    localparam int HDR_BYTES    = 4;
    localparam int FTR_BYTES    = 2;
    localparam int FRAME_LEN    = HDR_BYTES + SLOT_BYTES * TARGET_SLOTS + FTR_BYTES;

    localparam int FILL_W     = $clog2(FRAME_LEN + 1);
    localparam int SLOT_IDX_W = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
    localparam int PCNT_W     = $clog2(TARGET_SLOTS + 1);
    localparam int SHIFT_W    = $clog2(SLOT_BYTES + 1);

    localparam int WORD_W     = 16;
    localparam int SQ_W       = 2 * WORD_W;
    localparam int ROOT_STEPS = WORD_W;
    localparam int STEP_W     = $clog2(SQ_W);
    localparam int REM_W      = WORD_W + 1;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] HDR_1     = 8'hFF;
    localparam logic [7:0] HDR_2     = 8'h03;
    localparam logic [7:0] HDR_3     = 8'h00;
    localparam logic [7:0] FTR_0     = 8'h55;
    localparam logic [7:0] FTR_1     = 8'hCC;

    typedef logic [7:0]            t_byte;
    typedef logic [WORD_W-1:0]     t_word;
    typedef logic [FILL_W-1:0]     t_fill;
    typedef logic [SLOT_IDX_W-1:0] t_slot_idx;
    typedef logic [PCNT_W-1:0]     t_pcount;
    typedef logic [SHIFT_W-1:0]    t_shift_cnt;
    typedef logic [STEP_W-1:0]     t_step;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CALC,
        ST_SHIFT
    } t_state;

    typedef enum logic [1:0] {
        DP_IDLE,
        DP_SQUARE,
        DP_ROOT
    } t_dist_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         slot;
        logic               present;
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
        logic signed [15:0] speed;
        logic [15:0]        resolution;
        logic [15:0]        distance_mm;
        logic [1:0]         present_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic  push;
        logic  shift;
        logic  clear;
        logic  drop;
        t_byte data;
    } t_buf_ctl;

    typedef struct packed {
        logic    fill_zero;
        logic    full;
        logic    frame_ok;
        t_pcount present_count;
    } t_buf_status;

    typedef struct packed {
        t_word x_raw;
        t_word y_raw;
        t_word sp_raw;
        t_word rs_raw;
    } t_slot_words;

endpackage

// File: rtl/core/rtfp_if.sv
interface rtfp_in_if;
    logic               valid;
    logic               ready;
    rtfp_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtfp_out_if;
    logic                valid;
    logic                ready;
    rtfp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/radar_target_frame_parser.sv
// Radar target frame parser. Takes one serial byte per request on i_rx; while nothing is
// held, bytes other than 0xAA are dropped. Once 30 bytes are held, a header AA FF 03 00 and
// footer 55 CC mark a good frame, which gives three slot results on o_tgt (last set on the
// third); a bad frame slides the window by one byte. A dropped byte leaves the parser idle;
// a held byte also passes through a check state. The byte that completes a good frame
// keeps the input busy while each slot runs through a bit-serial distance unit (shift-add
// squaring of X and Y, then root digits), and between slots the byte shift line moves the
// next slot into place. A result waits in an output register, so the next slot is
// computed, and after the last one new bytes are taken, while it waits.
module radar_target_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtfp_in_if.sink     i_rx,
    rtfp_out_if.source  o_tgt
);

    rtfp_pkg::t_state       r_state;
    rtfp_pkg::t_state       n_state;
    rtfp_pkg::t_slot_idx    r_slot;
    rtfp_pkg::t_pcount      r_pcount;
    rtfp_pkg::t_shift_cnt   r_sh;
    rtfp_pkg::t_out_item    r_out;
    rtfp_pkg::t_out_item    n_out;
    logic                   r_out_valid;

    rtfp_pkg::t_buf_ctl     buf_ctl;
    rtfp_pkg::t_buf_status  buf_status;
    rtfp_pkg::t_slot_words  words;

    logic            in_acc;
    logic            push_ok;
    logic            out_acc;
    logic            out_free;
    logic            dist_busy;
    logic            dist_start;
    rtfp_pkg::t_word dist_root;
    logic            load;
    logic            last_slot;
    logic            good;
    logic            shift_done;
    logic            pres;
    rtfp_pkg::t_word x_mag;
    rtfp_pkg::t_word y_mag;

    rtfp_frame_buf u_frame_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (buf_ctl),
        .o_status (buf_status),
        .o_words  (words)
    );

    rtfp_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_x_mag (x_mag),
        .i_y_mag (y_mag),
        .o_busy  (dist_busy),
        .o_root  (dist_root)
    );

    always_comb begin
        in_acc     = i_rx.valid && (r_state == rtfp_pkg::ST_IDLE);
        push_ok    = in_acc && (!buf_status.fill_zero ||
                                (i_rx.data.rx_byte == rtfp_pkg::SYNC_BYTE));
        out_acc    = r_out_valid && o_tgt.ready;
        out_free   = !r_out_valid || o_tgt.ready;
        load       = (r_state == rtfp_pkg::ST_CALC) && !dist_busy && out_free;
        last_slot  = (r_slot == rtfp_pkg::t_slot_idx'(rtfp_pkg::TARGET_SLOTS - 1));
        good       = (r_state == rtfp_pkg::ST_CHECK) && buf_status.full &&
                     buf_status.frame_ok;
        shift_done = (r_sh == rtfp_pkg::t_shift_cnt'(rtfp_pkg::SLOT_BYTES));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtfp_pkg::ST_IDLE: begin
                if (push_ok) begin
                    n_state = rtfp_pkg::ST_CHECK;
                end
            end
            rtfp_pkg::ST_CHECK: begin
                n_state = good ? rtfp_pkg::ST_CALC : rtfp_pkg::ST_IDLE;
            end
            rtfp_pkg::ST_CALC: begin
                if (load) begin
                    n_state = last_slot ? rtfp_pkg::ST_IDLE : rtfp_pkg::ST_SHIFT;
                end
            end
            rtfp_pkg::ST_SHIFT: begin
                if (shift_done) begin
                    n_state = rtfp_pkg::ST_CALC;
                end
            end
        endcase
    end

    always_comb begin
        i_rx.ready    = (r_state == rtfp_pkg::ST_IDLE);
        buf_ctl.push  = push_ok;
        buf_ctl.shift = (r_state == rtfp_pkg::ST_SHIFT) && !shift_done;
        buf_ctl.clear = load && last_slot;
        buf_ctl.drop  = (r_state == rtfp_pkg::ST_CHECK) && buf_status.full &&
                        !buf_status.frame_ok;
        buf_ctl.data  = (r_state == rtfp_pkg::ST_IDLE) ? i_rx.data.rx_byte : '0;
        dist_start    = good || ((r_state == rtfp_pkg::ST_SHIFT) && shift_done);
        o_tgt.valid   = r_out_valid;
        o_tgt.data    = r_out;
    end

    // x is sign-magnitude with bit 15 as the sign, y is offset binary
    always_comb begin
        pres  = (words.x_raw != '0) || (words.y_raw != '0) || (words.rs_raw != '0);
        x_mag = {1'b0, words.x_raw[rtfp_pkg::WORD_W-2:0]};
        y_mag = words.y_raw[rtfp_pkg::WORD_W-1] ?
                {1'b0, words.y_raw[rtfp_pkg::WORD_W-2:0]} :
                rtfp_pkg::t_word'(17'h08000 - {2'b00, words.y_raw[rtfp_pkg::WORD_W-2:0]});

        n_out.slot          = 2'(r_slot);
        n_out.present       = pres;
        n_out.x_mm          = '0;
        n_out.y_mm          = '0;
        n_out.speed         = '0;
        n_out.distance_mm   = '0;
        n_out.resolution    = words.rs_raw;
        n_out.present_count = 2'(r_pcount);
        n_out.last          = last_slot;
        if (pres) begin
            n_out.x_mm        = words.x_raw[rtfp_pkg::WORD_W-1] ? x_mag : (16'h0000 - x_mag);
            n_out.y_mm        = {~words.y_raw[rtfp_pkg::WORD_W-1],
                                 words.y_raw[rtfp_pkg::WORD_W-2:0]};
            n_out.speed       = words.sp_raw;
            n_out.distance_mm = dist_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rtfp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_slot      <= '0;
            r_sh        <= '0;
            r_pcount    <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (good) begin
                r_slot   <= '0;
                r_pcount <= buf_status.present_count;
            end else if (dist_start) begin
                r_slot <= r_slot + rtfp_pkg::t_slot_idx'(1);
            end
            if (load) begin
                r_sh <= '0;
            end else if (buf_ctl.shift) begin
                r_sh <= r_sh + rtfp_pkg::t_shift_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/core/rtfp_frame_buf.sv
module rtfp_frame_buf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rtfp_pkg::t_buf_ctl     i_ctl,
    output rtfp_pkg::t_buf_status  o_status,
    output rtfp_pkg::t_slot_words  o_words
);

    // byte shift line: new bytes enter at the top, oldest byte sits at index 0 when full
    rtfp_pkg::t_byte r_buf [rtfp_pkg::FRAME_LEN];
    rtfp_pkg::t_fill r_fill;
    rtfp_pkg::t_fill n_fill;
    rtfp_pkg::t_pcount pcount;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push || i_ctl.shift) begin
            for (int i = 0; i < rtfp_pkg::FRAME_LEN - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[rtfp_pkg::FRAME_LEN-1] <= i_ctl.data;
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.clear) begin
            n_fill = '0;
        end else if (i_ctl.drop) begin
            n_fill = rtfp_pkg::t_fill'(rtfp_pkg::FRAME_LEN - 1);
        end else if (i_ctl.push) begin
            n_fill = r_fill + rtfp_pkg::t_fill'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_comb begin
        pcount = '0;
        for (int s = 0; s < rtfp_pkg::TARGET_SLOTS; s++) begin
            if ({r_buf[rtfp_pkg::HDR_BYTES + rtfp_pkg::SLOT_BYTES * s + 1],
                 r_buf[rtfp_pkg::HDR_BYTES + rtfp_pkg::SLOT_BYTES * s],
                 r_buf[rtfp_pkg::HDR_BYTES + rtfp_pkg::SLOT_BYTES * s + 3],
                 r_buf[rtfp_pkg::HDR_BYTES + rtfp_pkg::SLOT_BYTES * s + 2],
                 r_buf[rtfp_pkg::HDR_BYTES + rtfp_pkg::SLOT_BYTES * s + 7],
                 r_buf[rtfp_pkg::HDR_BYTES + rtfp_pkg::SLOT_BYTES * s + 6]} != '0) begin
                pcount = pcount + rtfp_pkg::t_pcount'(1);
            end
        end
    end

    always_comb begin
        o_status.fill_zero     = (r_fill == '0);
        o_status.full          = (r_fill == rtfp_pkg::t_fill'(rtfp_pkg::FRAME_LEN));
        o_status.frame_ok      = (r_buf[0] == rtfp_pkg::SYNC_BYTE) &&
                                 (r_buf[1] == rtfp_pkg::HDR_1) &&
                                 (r_buf[2] == rtfp_pkg::HDR_2) &&
                                 (r_buf[3] == rtfp_pkg::HDR_3) &&
                                 (r_buf[rtfp_pkg::FRAME_LEN-2] == rtfp_pkg::FTR_0) &&
                                 (r_buf[rtfp_pkg::FRAME_LEN-1] == rtfp_pkg::FTR_1);
        o_status.present_count = pcount;
    end

    // the slot being decoded always sits at the byte positions right after the header
    always_comb begin
        o_words.x_raw  = {r_buf[rtfp_pkg::HDR_BYTES + 1], r_buf[rtfp_pkg::HDR_BYTES]};
        o_words.y_raw  = {r_buf[rtfp_pkg::HDR_BYTES + 3], r_buf[rtfp_pkg::HDR_BYTES + 2]};
        o_words.sp_raw = {r_buf[rtfp_pkg::HDR_BYTES + 5], r_buf[rtfp_pkg::HDR_BYTES + 4]};
        o_words.rs_raw = {r_buf[rtfp_pkg::HDR_BYTES + 7], r_buf[rtfp_pkg::HDR_BYTES + 6]};
    end

endmodule

// File: rtl/core/rtfp_dist.sv
module rtfp_dist (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rtfp_pkg::t_word i_x_mag,
    input  rtfp_pkg::t_word i_y_mag,
    output logic            o_busy,
    output rtfp_pkg::t_word o_root
);

    rtfp_pkg::t_dist_phase r_phase;
    rtfp_pkg::t_dist_phase n_phase;
    rtfp_pkg::t_step       r_step;
    rtfp_pkg::t_word       r_mplier;
    rtfp_pkg::t_word       r_y;
    logic [rtfp_pkg::SQ_W-1:0]  r_mcand;
    logic [rtfp_pkg::SQ_W-1:0]  r_acc;
    logic [rtfp_pkg::REM_W-1:0] r_rem;
    rtfp_pkg::t_word       r_root;
    logic [rtfp_pkg::REM_W+2:0] trial;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            rtfp_pkg::DP_IDLE: begin
                if (i_start) begin
                    n_phase = rtfp_pkg::DP_SQUARE;
                end
            end
            rtfp_pkg::DP_SQUARE: begin
                if (r_step == rtfp_pkg::t_step'(rtfp_pkg::SQ_W - 1)) begin
                    n_phase = rtfp_pkg::DP_ROOT;
                end
            end
            rtfp_pkg::DP_ROOT: begin
                if (r_step == rtfp_pkg::t_step'(rtfp_pkg::ROOT_STEPS - 1)) begin
                    n_phase = rtfp_pkg::DP_IDLE;
                end
            end
            default: begin
                n_phase = rtfp_pkg::DP_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy = (r_phase != rtfp_pkg::DP_IDLE);
        o_root = r_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rtfp_pkg::DP_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // one root digit: bring down two bits of the radicand, try subtracting 4*root+1
    assign trial = {1'b0, r_rem, r_acc[rtfp_pkg::SQ_W-1 -: 2]} -
                   {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            rtfp_pkg::DP_IDLE: begin
                if (i_start) begin
                    r_mplier <= i_x_mag;
                    r_mcand  <= {{rtfp_pkg::WORD_W{1'b0}}, i_x_mag};
                    r_y      <= i_y_mag;
                    r_acc    <= '0;
                    r_step   <= '0;
                end
            end
            rtfp_pkg::DP_SQUARE: begin
                // shift-add squaring, one multiplier bit a cycle, x first then y
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                if (r_step == rtfp_pkg::t_step'(rtfp_pkg::WORD_W - 1)) begin
                    r_mplier <= r_y;
                    r_mcand  <= {{rtfp_pkg::WORD_W{1'b0}}, r_y};
                end else begin
                    r_mplier <= r_mplier >> 1;
                    r_mcand  <= r_mcand << 1;
                end
                r_step <= r_step + rtfp_pkg::t_step'(1);
                r_rem  <= '0;
                r_root <= '0;
            end
            rtfp_pkg::DP_ROOT: begin
                if (!trial[rtfp_pkg::REM_W+2]) begin
                    r_rem  <= trial[rtfp_pkg::REM_W-1:0];
                    r_root <= {r_root[rtfp_pkg::WORD_W-2:0], 1'b1};
                end else begin
                    r_rem  <= {r_rem[rtfp_pkg::REM_W-3:0], r_acc[rtfp_pkg::SQ_W-1 -: 2]};
                    r_root <= {r_root[rtfp_pkg::WORD_W-2:0], 1'b0};
                end
                r_acc  <= r_acc << 2;
                r_step <= r_step + rtfp_pkg::t_step'(1);
            end
            default: begin
                r_step <= '0;
            end
        endcase
    end

endmodule

// File: rtl/core/rtfp_checker.sv
module rtfp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input rtfp_pkg::t_out_item i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.last ==
                         (i_out_data.slot == 2'(rtfp_pkg::TARGET_SLOTS - 1))))
        else $error("last flag does not match final slot");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.present |->
            i_out_data.x_mm == 16'sd0 && i_out_data.y_mm == 16'sd0 &&
            i_out_data.speed == 16'sd0 && i_out_data.resolution == 16'd0 &&
            i_out_data.distance_mm == 16'd0)
        else $error("absent slot carries nonzero fields");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.present |-> i_out_data.present_count != 2'd0)
        else $error("present slot in a frame with zero present count");

endmodule

bind radar_target_frame_parser rtfp_checker u_rtfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tgt.valid),
    .i_out_ready (o_tgt.ready),
    .i_out_data  (o_tgt.data)
);
